// File: rtl/srtf_pkg.sv
// shared types and constants of the srtf tick scheduler
package srtf_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  // control from the sequencer to the minimum scanner
  typedef struct packed {
    logic clear;
    logic sample;
    logic slot_ok;
  } scan_ctl_t;

  // one result, as held until the output register takes it
  typedef struct packed {
    logic [15:0] end_tick;
    logic [15:0] first_start;
    logic [7:0]  running_id;
    logic        finished;
    logic        idle;
    logic        dropped;
  } result_t;

  localparam logic FUNC_ARRIVAL = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  // register index, taken from address bit 2
  localparam logic REG_CUTOFF = 1'b0;
  localparam logic [15:0] CUTOFF_RESET = 16'd100;

  localparam int ID_W       = 8;
  localparam int REM_W      = 8;
  localparam int OUT_TICK_W = 16;

  // job entry layout in memory: id, remaining, first start tick
  localparam int ID_LSB    = 0;
  localparam int REM_LSB   = ID_LSB + ID_W;
  localparam int START_LSB = REM_LSB + REM_W;

endpackage

// File: rtl/srtf_tick_scheduler.sv
// srtf tick scheduler: arrivals fill a job table, each tick runs the shortest job
// an arrival goes from the request to the emit state, a tick through the scan and update states first
// one request at a time: a new one is taken only when the result is in the output register;
//   the minimum search reads one table entry per cycle from the job memory
// reset (rst_n low, synchronous) empties the table, zeroes the tick counter and
//   sets start_cutoff to 100; job memory contents are not cleared
module srtf_tick_scheduler
  import srtf_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int TICK_WIDTH  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // job_id[7:0], burst[15:8]
  input  logic [0:0]  in_tuser,      // func[0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,     // running_id[7:0], first_start[23:8], end_tick[39:24]
  output logic [2:0]  out_tuser,     // dropped[0], idle[1], finished[2]
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W = START_LSB + TICK_WIDTH;

  // fsm
  state_t state_r, state_nxt;

  // slot flags live in flops so the purge and the free-slot search act at once
  logic [TABLE_DEPTH-1:0] slot_valid_r;
  logic [TABLE_DEPTH-1:0] slot_started_r;
  logic [TICK_WIDTH-1:0]  now_tick_r;
  logic [15:0]            cutoff_r;

  // scan sequencing
  logic [CNT_W-1:0] rd_cnt_r;
  logic             rd_pend_r;
  logic [IDX_W-1:0] rd_slot_r;

  result_t res_r;
  result_t res_nxt;
  result_t out_r;
  logic    out_tvalid_r;

  // control from the output decode
  logic rd_en;
  logic scan_clear;
  logic upd_en;
  logic emit_load;

  // request decode
  logic       in_accept;
  logic       is_tick;
  logic       cutoff_hit;
  logic [7:0] req_id;
  logic [7:0] req_burst;

  // lowest free slot
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  // memory ports
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;

  // scanner
  scan_ctl_t         scan_ctl;
  logic              best_found;
  logic [IDX_W-1:0]  best_idx;
  logic [ID_W-1:0]   best_id;
  logic [REM_W-1:0]  best_rem;
  logic [TICK_WIDTH-1:0] best_start;

  // update of the chosen job
  logic                  upd_done;
  logic [TICK_WIDTH-1:0] upd_start;
  logic [REM_W-1:0]      upd_rem;

  logic cfg_write;

  assign in_accept  = in_tvalid && in_tready;
  assign is_tick    = (in_tuser[0] == FUNC_TICK);
  assign req_id     = in_tdata[7:0];
  assign req_burst  = in_tdata[15:8];
  assign cutoff_hit = (32'(now_tick_r) >= 32'(cutoff_r));

  // priority search, lowest index wins
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int s = TABLE_DEPTH - 1; s >= 0; s--) begin
      if (!slot_valid_r[s]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(s);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = is_tick ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        // the last entry is sampled in the cycle the counter reaches the depth
        if (rd_cnt_r == CNT_W'(TABLE_DEPTH)) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready  = 1'b0;
    rd_en      = 1'b0;
    scan_clear = 1'b0;
    upd_en     = 1'b0;
    emit_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        scan_clear = 1'b1;
      end
      ST_SCAN: begin
        rd_en = (rd_cnt_r != CNT_W'(TABLE_DEPTH));
      end
      ST_UPDATE: upd_en = 1'b1;
      ST_EMIT: begin
        emit_load = !out_tvalid_r || out_tready;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // scan read sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r  <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= rd_en;
      if (state_r == ST_IDLE) begin
        rd_cnt_r <= '0;
      end else if (rd_en) begin
        rd_cnt_r <= rd_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_slot_r <= rd_cnt_r[IDX_W-1:0];
    end
  end

  assign scan_ctl.clear   = scan_clear;
  assign scan_ctl.sample  = rd_pend_r;
  assign scan_ctl.slot_ok = slot_valid_r[rd_slot_r];

  // chosen job: first start is now unless it already ran; burst 0 finishes like 1
  assign upd_done  = (best_rem <= REM_W'(1));
  assign upd_start = slot_started_r[best_idx] ? best_start : now_tick_r;
  assign upd_rem   = upd_done ? '0 : (best_rem - REM_W'(1));

  // memory write: an arrival at request time or the write-back at update
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = free_idx;
    mem_wdata = {TICK_WIDTH'(0), req_burst, req_id};
    if (in_accept && !is_tick) begin
      mem_we = free_found;
    end else if (upd_en) begin
      mem_we    = best_found;
      mem_waddr = best_idx;
      mem_wdata = {upd_start, upd_rem, best_id};
    end
  end

  srtf_job_mem #(
    .DEPTH  (TABLE_DEPTH),
    .DATA_W (ENTRY_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (rd_cnt_r[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  srtf_min_scan #(
    .DEPTH  (TABLE_DEPTH),
    .TICK_W (TICK_WIDTH)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .slot       (rd_slot_r),
    .rd_data    (mem_rdata),
    .best_found (best_found),
    .best_idx   (best_idx),
    .best_id    (best_id),
    .best_rem   (best_rem),
    .best_start (best_start)
  );

  // slot flags and tick counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r   <= '0;
      slot_started_r <= '0;
      now_tick_r     <= '0;
    end else begin
      if (in_accept && !is_tick && free_found) begin
        slot_valid_r[free_idx]   <= 1'b1;
        slot_started_r[free_idx] <= 1'b0;
      end else if (in_accept && is_tick && cutoff_hit) begin
        // purge jobs that never ran, before the search
        slot_valid_r <= slot_valid_r & slot_started_r;
      end else if (upd_en) begin
        if (best_found) begin
          slot_started_r[best_idx] <= 1'b1;
          if (upd_done) begin
            slot_valid_r[best_idx] <= 1'b0;
          end
        end
        now_tick_r <= now_tick_r + TICK_WIDTH'(1);
      end
    end
  end

  // pending result
  always_comb begin
    res_nxt = '0;
    if (in_accept && !is_tick) begin
      res_nxt.dropped = !free_found;
    end else if (upd_en) begin
      if (!best_found) begin
        res_nxt.idle = 1'b1;
      end else begin
        res_nxt.running_id = best_id;
        if (upd_done) begin
          res_nxt.finished    = 1'b1;
          res_nxt.first_start = OUT_TICK_W'(upd_start);
          res_nxt.end_tick    = OUT_TICK_W'(now_tick_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((in_accept && !is_tick) || upd_en) begin
      res_r <= res_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (emit_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_r <= res_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_r.end_tick, out_r.first_start, out_r.running_id};
  assign out_tuser  = {out_r.finished, out_r.idle, out_r.dropped};

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_CUTOFF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= CUTOFF_RESET;
    end else if (cfg_write) begin
      cutoff_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_CUTOFF) ? {16'd0, cutoff_r} : 32'd0;

`ifndef SYNTHESIS
  // the job memory is never written while the search reads it
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> !mem_we)
    else $error("job memory written during scan");

  // the read counter never runs past the table
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> rd_cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("scan counter beyond table depth");

  // after a purging tick no unstarted job is left in the table
  a_purge: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && is_tick && cutoff_hit) |=> ((slot_valid_r & ~slot_started_r) == '0))
    else $error("unstarted job survived the cutoff purge");

  // a finished job is never reported with idle or dropped
  a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> !(res_r.finished && (res_r.idle || res_r.dropped)))
    else $error("inconsistent result flags");

  // results only leave through the emit state
  a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_EMIT))
    else $error("result presented outside emit");
`endif

endmodule

// File: rtl/srtf_job_mem.sv
// job table memory: one write port, one registered read port
module srtf_job_mem #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/srtf_min_scan.sv
// running minimum of remaining time over the entries streamed from memory
module srtf_min_scan
  import srtf_pkg::*;
#(
  parameter int DEPTH  = 16,
  parameter int TICK_W = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  scan_ctl_t                       ctl,
  input  logic [$clog2(DEPTH)-1:0]        slot,
  input  logic [START_LSB+TICK_W-1:0]     rd_data,
  output logic                            best_found,
  output logic [$clog2(DEPTH)-1:0]        best_idx,
  output logic [ID_W-1:0]                 best_id,
  output logic [REM_W-1:0]                best_rem,
  output logic [TICK_W-1:0]               best_start
);

  logic [REM_W-1:0] cand_rem;
  logic             take;

  logic                     found_r;
  logic [$clog2(DEPTH)-1:0] idx_r;
  logic [ID_W-1:0]          id_r;
  logic [REM_W-1:0]         rem_r;
  logic [TICK_W-1:0]        start_r;

  assign cand_rem = rd_data[REM_LSB +: REM_W];
  // strict less-than keeps the lowest slot on a tie
  assign take = ctl.sample && ctl.slot_ok && (!found_r || (cand_rem < rem_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clear) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      idx_r   <= slot;
      id_r    <= rd_data[ID_LSB +: ID_W];
      rem_r   <= cand_rem;
      start_r <= rd_data[START_LSB +: TICK_W];
    end
  end

  assign best_found = found_r;
  assign best_idx   = idx_r;
  assign best_id    = id_r;
  assign best_rem   = rem_r;
  assign best_start = start_r;

endmodule

// File: dv/srtf_tick_scheduler_tb.sv
// testbench for the srtf tick scheduler: directed table, then random requests against a predictor
`timescale 1ns / 1ps

module srtf_tick_scheduler_tb
  import srtf_pkg::*;
();

  localparam int DEPTH = 16;
  // run limit: far beyond the slowest correct run
  localparam int RUN_LIMIT_NS = 5_000_000;

  // how a directed row is checked: typed-in result or the predictor
  typedef enum logic [1:0] {
    BY_MODEL,
    WANT_ACCEPT,
    WANT_DROP,
    WANT_IDLE
  } check_kind_t;

  typedef struct {
    logic        func;
    logic [7:0]  job;
    logic [7:0]  burst;
    check_kind_t chk;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;     // job_id[7:0], burst[15:8]
  logic [0:0]  in_tuser;     // func[0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;    // running_id[7:0], first_start[23:8], end_tick[39:24]
  logic [2:0]  out_tuser;    // dropped[0], idle[1], finished[2]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // predictor state: the job table, the tick counter and the cutoff register
  logic        tbl_busy  [DEPTH];
  logic [7:0]  tbl_tag   [DEPTH];
  logic [7:0]  tbl_left  [DEPTH];
  logic        tbl_ran   [DEPTH];
  logic [15:0] tbl_first [DEPTH];
  logic [15:0] tick_now;
  logic [15:0] cutoff_shadow;

  // results still owed by the block, oldest first
  result_t     sched_outcomes[$];
  stim_row_t   directed_rows[$];
  int          mismatch_count;

  // idling controls of the sender and the receiver process
  bit          sender_gaps;
  bit          receiver_stalls;
  bit          hold_off_req;

  result_t     mon_want;
  result_t     mon_got;

  srtf_tick_scheduler DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // the scheduler itself, one request at a time; updates the table and returns the result
  function automatic result_t predict_schedule(input logic func, input logic [7:0] job,
                                               input logic [7:0] burst);
    result_t r;
    int      pick;
    bit      placed;
    r = '0;
    pick = -1;
    placed = 1'b0;
    if (func == FUNC_ARRIVAL) begin
      // lowest free slot takes the job, otherwise it is turned away
      for (int s = 0; s < DEPTH; s++) begin
        if (!placed && !tbl_busy[s]) begin
          tbl_busy[s]  = 1'b1;
          tbl_tag[s]   = job;
          tbl_left[s]  = burst;
          tbl_ran[s]   = 1'b0;
          tbl_first[s] = '0;
          placed = 1'b1;
        end
      end
      r.dropped = !placed;
      return r;
    end
    // at or past the cutoff, jobs that never ran are thrown out before the pick
    if (tick_now >= cutoff_shadow) begin
      for (int s = 0; s < DEPTH; s++)
        if (tbl_busy[s] && !tbl_ran[s]) tbl_busy[s] = 1'b0;
    end
    // strict less-than keeps ties on the lowest slot
    for (int s = 0; s < DEPTH; s++) begin
      if (tbl_busy[s] && (pick < 0 || tbl_left[s] < tbl_left[pick])) pick = s;
    end
    if (pick < 0) begin
      r.idle = 1'b1;
    end else begin
      r.running_id = tbl_tag[pick];
      if (!tbl_ran[pick]) begin
        tbl_ran[pick]   = 1'b1;
        tbl_first[pick] = tick_now;
      end
      // a zero burst counts as one unit
      if (tbl_left[pick] <= 8'd1) begin
        tbl_left[pick]  = '0;
        tbl_busy[pick]  = 1'b0;
        r.finished      = 1'b1;
        r.first_start   = tbl_first[pick];
        r.end_tick      = tick_now;
      end else begin
        tbl_left[pick] = tbl_left[pick] - 8'd1;
      end
    end
    tick_now = tick_now + 16'd1;
    return r;
  endfunction

  task automatic add_row(input logic func, input logic [7:0] job, input logic [7:0] burst,
                         input check_kind_t chk);
    stim_row_t row;
    row.func  = func;
    row.job   = job;
    row.burst = burst;
    row.chk   = chk;
    directed_rows.push_back(row);
  endtask

  // offer one request, wait for it to be taken, then book its expected result
  task automatic push_request(input logic func, input logic [7:0] job, input logic [7:0] burst,
                              input check_kind_t chk);
    result_t r;
    int      gap;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 17);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {burst, job};
    do @(posedge clk); while (!in_tready);
    // the predictor runs for every row; typed rows replace only the expectation
    r = predict_schedule(func, job, burst);
    case (chk)
      WANT_ACCEPT: r = '0;
      WANT_DROP: begin
        r = '0;
        r.dropped = 1'b1;
      end
      WANT_IDLE: begin
        r = '0;
        r.idle = 1'b1;
      end
      default: ;
    endcase
    sched_outcomes.push_back(r);
  endtask

  // drop valid and wait until every booked result has come back
  task automatic drain_results;
    in_tvalid <= 1'b0;
    while (sched_outcomes.size() != 0) @(posedge clk);
  endtask

  // write the cutoff over the config port, then read it back
  task automatic write_cutoff(input logic [15:0] val);
    logic [31:0] rd;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_CUTOFF, 2'b00};
    cfg_pwdata  <= {16'h0000, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cutoff_shadow = val;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd !== {16'h0000, cutoff_shadow}) begin
      $error("start_cutoff readback: expected %0h, got %0h", {16'h0000, cutoff_shadow}, rd);
      mismatch_count++;
    end
  endtask

  // random requests; mostly short bursts so jobs come and go, now and then a full-range one
  task automatic random_requests(input int count, input int arrive_pct);
    logic       func;
    logic [7:0] job;
    logic [7:0] burst;
    repeat (count) begin
      func  = ($urandom_range(0, 99) < arrive_pct) ? FUNC_ARRIVAL : FUNC_TICK;
      job   = 8'($urandom_range(0, 255));
      burst = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(1, 8));
      push_request(func, job, burst, BY_MODEL);
    end
  endtask

  // receiver: random stall bursts, plus one long hold-off on request so the block backs up
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off_req = 1'b0;
        out_tready <= 1'b1;
      end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // result checker: every accepted result against the oldest booked one
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (sched_outcomes.size() == 0) begin
        $error("result with no request outstanding: tuser %0h tdata %0h", out_tuser, out_tdata);
        mismatch_count++;
      end else begin
        mon_want = sched_outcomes.pop_front();
        mon_got  = '0;
        mon_got.dropped     = out_tuser[0];
        mon_got.idle        = out_tuser[1];
        mon_got.finished    = out_tuser[2];
        mon_got.running_id  = out_tdata[7:0];
        mon_got.first_start = out_tdata[23:8];
        mon_got.end_tick    = out_tdata[39:24];
        if (mon_got.dropped !== mon_want.dropped) begin
          $error("dropped: expected %0h, got %0h", mon_want.dropped, mon_got.dropped);
          mismatch_count++;
        end
        if (mon_got.idle !== mon_want.idle) begin
          $error("idle: expected %0h, got %0h", mon_want.idle, mon_got.idle);
          mismatch_count++;
        end
        if (mon_got.running_id !== mon_want.running_id) begin
          $error("running_id: expected %0h, got %0h", mon_want.running_id, mon_got.running_id);
          mismatch_count++;
        end
        if (mon_got.finished !== mon_want.finished) begin
          $error("finished: expected %0h, got %0h", mon_want.finished, mon_got.finished);
          mismatch_count++;
        end
        if (mon_got.first_start !== mon_want.first_start) begin
          $error("first_start: expected %0h, got %0h", mon_want.first_start,
                 mon_got.first_start);
          mismatch_count++;
        end
        if (mon_got.end_tick !== mon_want.end_tick) begin
          $error("end_tick: expected %0h, got %0h", mon_want.end_tick, mon_got.end_tick);
          mismatch_count++;
        end
      end
    end
  end

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL srtf_tick_scheduler");
    $finish;
  end

  initial begin
    // everything known from time zero, with reset held low at the start
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    mismatch_count = 0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    hold_off_req    = 1'b0;
    for (int s = 0; s < DEPTH; s++) begin
      tbl_busy[s]  = 1'b0;
      tbl_tag[s]   = '0;
      tbl_left[s]  = '0;
      tbl_ran[s]   = 1'b0;
      tbl_first[s] = '0;
    end
    tick_now      = '0;
    cutoff_shadow = CUTOFF_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, cutoff at its reset value
    add_row(FUNC_TICK,    8'h00, 8'h00, WANT_IDLE);   // empty table after reset
    add_row(FUNC_ARRIVAL, 8'hFF, 8'h00, WANT_ACCEPT); // zero burst, top id
    add_row(FUNC_TICK,    8'hFF, 8'hFF, BY_MODEL);    // zero burst finishes at once
    add_row(FUNC_ARRIVAL, 8'h00, 8'hFF, WANT_ACCEPT); // longest burst, id zero
    add_row(FUNC_ARRIVAL, 8'h5A, 8'h03, WANT_ACCEPT); // tie pair: lower slot first
    add_row(FUNC_ARRIVAL, 8'hA5, 8'h03, WANT_ACCEPT);
    for (int k = 0; k < DEPTH - 3; k++)
      add_row(FUNC_ARRIVAL, 8'(8'h10 + k), 8'(200 - k), WANT_ACCEPT);
    add_row(FUNC_ARRIVAL, 8'h77, 8'h01, WANT_DROP);   // table full
    add_row(FUNC_TICK,    8'h00, 8'h00, BY_MODEL);
    add_row(FUNC_TICK,    8'h00, 8'h00, BY_MODEL);
    add_row(FUNC_TICK,    8'h00, 8'h00, BY_MODEL);
    add_row(FUNC_TICK,    8'h00, 8'h00, BY_MODEL);
    foreach (directed_rows[i])
      push_request(directed_rows[i].func, directed_rows[i].job, directed_rows[i].burst,
                   directed_rows[i].chk);
    drain_results();

    // cutoff at zero: every unstarted job is purged on each tick
    write_cutoff(16'h0000);
    random_requests(100, 50);
    drain_results();

    // cutoff at the top: nothing purged; long receiver hold-off fills the block
    write_cutoff(16'hFFFF);
    hold_off_req = 1'b1;
    random_requests(350, 40);
    drain_results();

    // cutoff a little ahead, so purging starts part way through; sender gaps only
    write_cutoff(16'(tick_now + 16'($urandom_range(40, 200))));
    receiver_stalls = 1'b0;
    random_requests(300, 55);
    drain_results();

    // cutoff anywhere; receiver stalls only
    write_cutoff(16'($urandom_range(0, 65535)));
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b1;
    random_requests(250, 45);
    drain_results();

    // last stretch back at the reset cutoff, with no idling on either side
    write_cutoff(CUTOFF_RESET);
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    random_requests(226, 45);
    drain_results();

    // allow for any stray result beyond the last expected one
    repeat (DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS srtf_tick_scheduler");
    end else begin
      $display("FAIL srtf_tick_scheduler");
    end
    $finish;
  end

endmodule

// File: srtf_tick_scheduler.f
rtl/srtf_pkg.sv
rtl/srtf_job_mem.sv
rtl/srtf_min_scan.sv
rtl/srtf_tick_scheduler.sv
dv/srtf_tick_scheduler_tb.sv
